[design/bfr_pkg.sv]
// Package for the brightness fade ramp: operation codes, sequencer states
// and the fixed field widths. No dependencies.
package bfr_pkg;

  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned FRAMES_W = 16;
  localparam int unsigned OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_REVERSE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

[design/brightness_fade_ramp_core.sv]
// Brightness fade ramp top level: fixed-point accumulator, fade bookkeeping
// and a restoring divider under a small sequencer. Uses bfr_pkg.
//
// Input channel (in_valid_i / in_stall_o): one beat carries an operation
// (frame tick, start fade, reverse fade) and the start-only fields.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per
// input beat, in order, with the level written to the selected screen.
// Configuration: cfg_we_i writes cfg_wdata_i into the screen select bit;
// write it only while the block is idle.
// A tick, a reverse, an immediate set or an unused code needs no division:
// the accepted beat passes through the done state into the output register.
// A start with a nonzero frame count first runs the step division one
// quotient bit per cycle in the divide state, then passes through the done
// state. The input is held off from accept until the sequencer is idle again,
// so a new beat is taken only after the last one has left the done state.
// Reset clears all state, the screen select and the output register; no fade
// is running afterward. A result waits in the output register while
// out_stall_i is high; one more beat may be accepted and finished meanwhile,
// and it then holds the input off until the output register frees up.
module brightness_fade_ramp_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bfr_pkg::OP_W-1:0]            operation_i,
  input  logic                                keep_current_i,
  input  logic signed [bfr_pkg::LEVEL_W-1:0]  start_level_i,
  input  logic signed [bfr_pkg::LEVEL_W-1:0]  target_level_i,
  input  logic [bfr_pkg::FRAMES_W-1:0]        frame_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                write_valid_o,
  output logic                                screen_o,
  output logic signed [bfr_pkg::LEVEL_W-1:0]  level_out_o,
  output logic                                fade_active_o,
  output logic                                ended_at_zero_o
);

  localparam int unsigned ACC_W  = FRAC_BITS + bfr_pkg::LEVEL_W;
  localparam int unsigned STEP_W = FRAC_BITS + bfr_pkg::LEVEL_W + 1;
  localparam int unsigned FW     = bfr_pkg::FRAMES_W;
  localparam int unsigned LW     = bfr_pkg::LEVEL_W;
  localparam int unsigned CNT_W  = $clog2(STEP_W);

  // Architectural state.
  logic                     screen_sel_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [STEP_W-1:0] step_q;
  logic signed [LW-1:0]     from_q;
  logic signed [LW-1:0]     to_q;
  logic [FW-1:0]            total_q;
  logic [FW-1:0]            left_q;
  logic                     running_q;

  // Sequencer and divider.
  bfr_pkg::state_e          state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic [STEP_W-1:0]        quo_q;     // dividend bits shift out, quotient bits in
  logic [FW-1:0]            rem_q;
  logic [FW-1:0]            divisor_q;
  logic                     neg_q;

  // Pending result.
  logic                     res_wr_q;
  logic                     res_az_q;

  // Output register.
  logic                     out_valid_q;
  logic                     out_wr_q;
  logic                     out_screen_q;
  logic signed [LW-1:0]     out_level_q;
  logic                     out_active_q;
  logic                     out_az_q;

  logic                     in_fire;
  logic                     out_free;
  logic                     div_last;
  bfr_pkg::op_e             op;

  assign op       = bfr_pkg::op_e'(operation_i);
  assign in_fire  = in_valid_i && (state_q == bfr_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (op == bfr_pkg::OP_START && frame_count_i != '0) begin
            state_d = bfr_pkg::ST_DIV;
          end else begin
            state_d = bfr_pkg::ST_DONE;
          end
        end
      end
      bfr_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = bfr_pkg::ST_DONE;
        end
      end
      bfr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bfr_pkg::ST_IDLE;
        end
      end
      default: state_d = bfr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Level of an accumulator value, truncated toward zero.
  logic signed [ACC_W-1:0] acc_start;
  logic signed [ACC_W-1:0] tgt_scaled;
  logic signed [ACC_W-1:0] to_scaled;
  logic signed [STEP_W-1:0] diff;
  logic [STEP_W-1:0]       diff_mag;
  logic [FW-1:0]           left_dec;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [LW-1:0]    acc_level;
  logic signed [LW-1:0]    start_level_of;
  logic [FW:0]             trial;
  logic                    take;
  logic [STEP_W-1:0]       quo_next;

  function automatic logic signed [LW-1:0] level_of(input logic signed [ACC_W-1:0] a);
    logic signed [LW-1:0] sh;
    sh = a[ACC_W-1:FRAC_BITS];
    if (a[ACC_W-1] && (a[FRAC_BITS-1:0] != '0)) begin
      sh = sh + LW'(1);
    end
    return sh;
  endfunction

  always_comb begin
    acc_start      = keep_current_i ? acc_q : {start_level_i, {FRAC_BITS{1'b0}}};
    tgt_scaled     = {target_level_i, {FRAC_BITS{1'b0}}};
    to_scaled      = {to_q, {FRAC_BITS{1'b0}}};
    diff           = STEP_W'(tgt_scaled) - STEP_W'(acc_start);
    diff_mag       = diff[STEP_W-1] ? STEP_W'(-diff) : STEP_W'(diff);
    start_level_of = level_of(acc_start);
    left_dec       = left_q - FW'(1);
    acc_sum        = acc_q + ACC_W'(step_q);
    acc_level      = level_of(acc_q);
    trial          = {rem_q, quo_q[STEP_W-1]};
    take           = (trial >= {1'b0, divisor_q});
    quo_next       = {quo_q[STEP_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_sel_q <= 1'b0;
      acc_q        <= '0;
      step_q       <= '0;
      from_q       <= '0;
      to_q         <= '0;
      total_q      <= '0;
      left_q       <= '0;
      running_q    <= 1'b0;
      cnt_q        <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      divisor_q    <= '0;
      neg_q        <= 1'b0;
      res_wr_q     <= 1'b0;
      res_az_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_wr_q     <= 1'b0;
      out_screen_q <= 1'b0;
      out_level_q  <= '0;
      out_active_q <= 1'b0;
      out_az_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        screen_sel_q <= cfg_wdata_i;
      end

      if (in_fire) begin
        res_wr_q <= 1'b0;
        res_az_q <= 1'b0;
        case (op)
          bfr_pkg::OP_START: begin
            if (frame_count_i == '0) begin
              acc_q    <= tgt_scaled;
              res_wr_q <= 1'b1;
            end else begin
              running_q <= 1'b1;
              acc_q     <= acc_start;
              from_q    <= start_level_of;
              to_q      <= target_level_i;
              total_q   <= frame_count_i;
              left_q    <= frame_count_i;
              quo_q     <= diff_mag;
              rem_q     <= '0;
              divisor_q <= frame_count_i;
              neg_q     <= diff[STEP_W-1];
              cnt_q     <= CNT_W'(STEP_W - 1);
            end
          end
          bfr_pkg::OP_REVERSE: begin
            if (running_q) begin
              step_q <= -step_q;
              left_q <= total_q - left_q;
              to_q   <= from_q;
              from_q <= to_q;
            end
          end
          bfr_pkg::OP_TICK: begin
            if (running_q) begin
              left_q   <= left_dec;
              res_wr_q <= 1'b1;
              if (left_dec == '0) begin
                running_q <= 1'b0;
                acc_q     <= to_scaled;
                res_az_q  <= (to_q == '0);
              end else begin
                acc_q <= acc_sum;
              end
            end
          end
          default: ;
        endcase
      end

      // One restoring quotient bit per cycle.
      if (state_q == bfr_pkg::ST_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
        quo_q <= quo_next;
        rem_q <= take ? FW'(trial - {1'b0, divisor_q}) : trial[FW-1:0];
        if (div_last) begin
          step_q <= neg_q ? STEP_W'(-quo_next) : quo_next;
        end
      end

      if (state_q == bfr_pkg::ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_wr_q     <= res_wr_q;
        out_screen_q <= screen_sel_q;
        out_level_q  <= res_wr_q ? acc_level : '0;
        out_active_q <= running_q;
        out_az_q     <= res_az_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o      = (state_q != bfr_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign write_valid_o   = out_wr_q;
  assign screen_o        = out_screen_q;
  assign level_out_o     = out_level_q;
  assign fade_active_o   = out_active_q;
  assign ended_at_zero_o = out_az_q;

endmodule
